// ----- rtl/cfuv_pkg.sv -----
// ----------------------------------------------------------------------------
// cfuv_pkg
// Shared constants, face encodings, the per-face mapping table and the
// control word that travels with each item through the divider pipeline.
// ----------------------------------------------------------------------------
package cfuv_pkg;

  localparam int CB_DEFAULT = 24;
  localparam int FB_DEFAULT = 15;

  // Face codes on face_select, dominant_face and used_face.
  localparam logic [2:0] FACE_PX  = 3'd0;
  localparam logic [2:0] FACE_NX  = 3'd1;
  localparam logic [2:0] FACE_PY  = 3'd2;
  localparam logic [2:0] FACE_NY  = 3'd3;
  localparam logic [2:0] FACE_PZ  = 3'd4;
  localparam logic [2:0] FACE_NZ  = 3'd5;
  localparam logic [2:0] FACE_DOM = 3'd6;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic [1:0] axis;
    logic [1:0] u_comp;
    logic       u_neg;
    logic [1:0] v_comp;
    logic       v_neg;
  } face_map_t;

  typedef struct packed {
    logic [2:0] dominant_face;
    logic [2:0] used_face;
    logic       u_edge;
    logic       u_hi;
    logic       v_edge;
    logic       v_hi;
  } coord_ctl_t;

  // Face axis and the signed components that give u and v.
  function automatic face_map_t face_map(input logic [2:0] face);
    face_map_t fm;
    case (face)
      FACE_PX: fm = '{axis: AXIS_X, u_comp: AXIS_Z, u_neg: 1'b1, v_comp: AXIS_Y, v_neg: 1'b1};
      FACE_NX: fm = '{axis: AXIS_X, u_comp: AXIS_Z, u_neg: 1'b0, v_comp: AXIS_Y, v_neg: 1'b1};
      FACE_PY: fm = '{axis: AXIS_Y, u_comp: AXIS_X, u_neg: 1'b0, v_comp: AXIS_Z, v_neg: 1'b0};
      FACE_NY: fm = '{axis: AXIS_Y, u_comp: AXIS_X, u_neg: 1'b0, v_comp: AXIS_Z, v_neg: 1'b1};
      FACE_PZ: fm = '{axis: AXIS_Z, u_comp: AXIS_X, u_neg: 1'b0, v_comp: AXIS_Y, v_neg: 1'b1};
      default: fm = '{axis: AXIS_Z, u_comp: AXIS_X, u_neg: 1'b1, v_comp: AXIS_Y, v_neg: 1'b1};
    endcase
    return fm;
  endfunction

endpackage

// ----- rtl/cfuv_front.sv -----
// ----------------------------------------------------------------------------
// cfuv_front
// Three-stage front end: input register, magnitudes and pairwise compares,
// then face choice, edge decisions and the divider operands.
// ----------------------------------------------------------------------------
module cfuv_front
  import cfuv_pkg::*;
#(
  parameter int COMPONENT_BITS = CB_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [COMPONENT_BITS-1:0] dir_x,
  input  logic signed [COMPONENT_BITS-1:0] dir_y,
  input  logic signed [COMPONENT_BITS-1:0] dir_z,
  input  logic [2:0]                       face_select,
  output logic                             out_valid,
  input  logic                             out_ready,
  output coord_ctl_t                       out_ctl,
  output logic [COMPONENT_BITS:0]          out_u_rem,
  output logic [COMPONENT_BITS:0]          out_v_rem,
  output logic [COMPONENT_BITS:0]          out_den
);

  localparam int CB = COMPONENT_BITS;

  localparam int GT_XY = 0;
  localparam int GT_YX = 1;
  localparam int GT_XZ = 2;
  localparam int GT_ZX = 3;
  localparam int GT_YZ = 4;
  localparam int GT_ZY = 5;

  function automatic logic pair_gt(input logic [1:0] a, input logic [1:0] b,
                                   input logic [5:0] gt);
    logic r;
    case ({a, b})
      {AXIS_X, AXIS_Y}: r = gt[GT_XY];
      {AXIS_Y, AXIS_X}: r = gt[GT_YX];
      {AXIS_X, AXIS_Z}: r = gt[GT_XZ];
      {AXIS_Z, AXIS_X}: r = gt[GT_ZX];
      {AXIS_Y, AXIS_Z}: r = gt[GT_YZ];
      {AXIS_Z, AXIS_Y}: r = gt[GT_ZY];
      default:          r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [CB-1:0] pick_mag(input logic [1:0] sel, input logic [CB-1:0] x,
                                             input logic [CB-1:0] y, input logic [CB-1:0] z);
    logic [CB-1:0] r;
    case (sel)
      AXIS_X:  r = x;
      AXIS_Y:  r = y;
      default: r = z;
    endcase
    return r;
  endfunction

  function automatic logic c_pos(input logic [CB-1:0] c);
    return !c[CB-1] && (c != '0);
  endfunction

  function automatic logic [CB-1:0] mag(input logic signed [CB-1:0] c);
    return c[CB-1] ? CB'(-c) : CB'(c);
  endfunction

  // Stage 1: input register.
  logic                 s1_valid_r;
  logic signed [CB-1:0] s1_x_r, s1_y_r, s1_z_r;
  logic [2:0]           s1_face_r;

  // Stage 2: magnitudes and strict pairwise compares.
  logic                 s2_valid_r;
  logic [CB-1:0]        s2_x_r, s2_y_r, s2_z_r;
  logic [CB-1:0]        s2_mx_r, s2_my_r, s2_mz_r;
  logic [5:0]           s2_gt_r;
  logic [2:0]           s2_face_r;

  // Stage 3: operands for the divider.
  logic                 s3_valid_r;
  coord_ctl_t           s3_ctl_r;
  logic [CB:0]          s3_u_rem_r, s3_v_rem_r, s3_den_r;

  logic rdy1, rdy2, rdy3;

  assign rdy3     = !s3_valid_r || out_ready;
  assign rdy2     = !s2_valid_r || rdy3;
  assign rdy1     = !s1_valid_r || rdy2;
  assign in_ready = rdy1;

  logic [CB-1:0] mx_nxt, my_nxt, mz_nxt;
  logic [5:0]    gt_nxt;

  always_comb begin
    mx_nxt = mag(s1_x_r);
    my_nxt = mag(s1_y_r);
    mz_nxt = mag(s1_z_r);
    gt_nxt[GT_XY] = mx_nxt > my_nxt;
    gt_nxt[GT_YX] = my_nxt > mx_nxt;
    gt_nxt[GT_XZ] = mx_nxt > mz_nxt;
    gt_nxt[GT_ZX] = mz_nxt > mx_nxt;
    gt_nxt[GT_YZ] = my_nxt > mz_nxt;
    gt_nxt[GT_ZY] = mz_nxt > my_nxt;
  end

  logic [2:0]           dom, face;
  face_map_t            fm;
  logic [CB-1:0]        d, cu, cv, ca;
  logic                 u_q, v_q, opp, u_bigger;
  logic                 u_npos, v_npos, eu_hi, ev_hi;
  logic signed [CB+1:0] cu_ext, cv_ext, nu_ext, nv_ext;
  logic [CB+1:0]        usum, vsum;
  coord_ctl_t           ctl_nxt;

  always_comb begin
    if (s2_gt_r[GT_XY] && s2_gt_r[GT_XZ]) begin
      dom = c_pos(s2_x_r) ? FACE_PX : FACE_NX;
    end else if (s2_gt_r[GT_YX] && s2_gt_r[GT_YZ]) begin
      dom = c_pos(s2_y_r) ? FACE_PY : FACE_NY;
    end else begin
      dom = c_pos(s2_z_r) ? FACE_PZ : FACE_NZ;
    end
    face = (s2_face_r >= FACE_DOM) ? dom : s2_face_r;
    fm   = face_map(face);

    d  = pick_mag(fm.axis,   s2_mx_r, s2_my_r, s2_mz_r);
    ca = pick_mag(fm.axis,   s2_x_r,  s2_y_r,  s2_z_r);
    cu = pick_mag(fm.u_comp, s2_x_r,  s2_y_r,  s2_z_r);
    cv = pick_mag(fm.v_comp, s2_x_r,  s2_y_r,  s2_z_r);

    u_q      = pair_gt(fm.axis, fm.u_comp, s2_gt_r);
    v_q      = pair_gt(fm.axis, fm.v_comp, s2_gt_r);
    u_bigger = pair_gt(fm.u_comp, fm.v_comp, s2_gt_r);

    // The face axis dominates but points away from the face.
    opp = u_q && v_q && (face[0] ? c_pos(ca) : ca[CB-1]);

    u_npos = fm.u_neg ? cu[CB-1] : c_pos(cu);
    v_npos = fm.v_neg ? cv[CB-1] : c_pos(cv);
    eu_hi  = c_pos(cu) ^ fm.u_neg;
    ev_hi  = c_pos(cv) ^ fm.v_neg;

    ctl_nxt.dominant_face = dom;
    ctl_nxt.used_face     = face;
    ctl_nxt.u_edge        = !u_q || (opp && u_bigger);
    ctl_nxt.u_hi          = u_q ? u_npos : eu_hi;
    ctl_nxt.v_edge        = !v_q || (opp && !u_bigger);
    ctl_nxt.v_hi          = v_q ? v_npos : ev_hi;

    // Dividend d + n stays in [1, 2d-1] whenever the coordinate is divided.
    cu_ext = {{2{cu[CB-1]}}, cu};
    cv_ext = {{2{cv[CB-1]}}, cv};
    nu_ext = fm.u_neg ? -cu_ext : cu_ext;
    nv_ext = fm.v_neg ? -cv_ext : cv_ext;
    usum   = {2'b00, d} + nu_ext;
    vsum   = {2'b00, d} + nv_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (rdy1) s1_valid_r <= in_valid;
      if (rdy2) s2_valid_r <= s1_valid_r;
      if (rdy3) s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_x_r    <= dir_x;
      s1_y_r    <= dir_y;
      s1_z_r    <= dir_z;
      s1_face_r <= face_select;
    end
    if (rdy2 && s1_valid_r) begin
      s2_x_r    <= s1_x_r;
      s2_y_r    <= s1_y_r;
      s2_z_r    <= s1_z_r;
      s2_mx_r   <= mx_nxt;
      s2_my_r   <= my_nxt;
      s2_mz_r   <= mz_nxt;
      s2_gt_r   <= gt_nxt;
      s2_face_r <= s1_face_r;
    end
    if (rdy3 && s2_valid_r) begin
      s3_ctl_r   <= ctl_nxt;
      s3_u_rem_r <= usum[CB:0];
      s3_v_rem_r <= vsum[CB:0];
      s3_den_r   <= {d, 1'b0};
    end
  end

  assign out_valid = s3_valid_r;
  assign out_ctl   = s3_ctl_r;
  assign out_u_rem = s3_u_rem_r;
  assign out_v_rem = s3_v_rem_r;
  assign out_den   = s3_den_r;

endmodule

// ----- rtl/cfuv_divider.sv -----
// ----------------------------------------------------------------------------
// cfuv_divider
// Pipelined restoring divider for u and v over a shared divisor, one
// quotient bit per stage and FRACTION_BITS stages.
// ----------------------------------------------------------------------------
module cfuv_divider
  import cfuv_pkg::*;
#(
  parameter int COMPONENT_BITS = CB_DEFAULT,
  parameter int FRACTION_BITS  = FB_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  coord_ctl_t                in_ctl,
  input  logic [COMPONENT_BITS:0]   in_u_rem,
  input  logic [COMPONENT_BITS:0]   in_v_rem,
  input  logic [COMPONENT_BITS:0]   in_den,
  output logic                      out_valid,
  input  logic                      out_ready,
  output coord_ctl_t                out_ctl,
  output logic [FRACTION_BITS-1:0]  out_u_quo,
  output logic [FRACTION_BITS-1:0]  out_v_quo
);

  localparam int CB = COMPONENT_BITS;
  localparam int FB = FRACTION_BITS;

  // Returns the quotient bit above the new partial remainder.
  function automatic logic [CB+1:0] div_step(input logic [CB:0] rem, input logic [CB:0] den);
    logic [CB+1:0] shifted, den_ext, diff;
    logic [CB+1:0] r;
    shifted = {rem, 1'b0};
    den_ext = {1'b0, den};
    diff    = shifted - den_ext;
    if (shifted >= den_ext) begin
      r = {1'b1, diff[CB:0]};
    end else begin
      r = {1'b0, shifted[CB:0]};
    end
    return r;
  endfunction

  logic [FB-1:0] vld_r;
  logic [FB:0]   rdy;
  coord_ctl_t    ctl_r  [FB];
  logic [CB:0]   urem_r [FB];
  logic [CB:0]   vrem_r [FB];
  logic [CB:0]   den_r  [FB];
  logic [FB-1:0] uq_r   [FB];
  logic [FB-1:0] vq_r   [FB];

  logic [FB-1:0] src_vld;
  coord_ctl_t    src_ctl  [FB];
  logic [CB:0]   src_urem [FB];
  logic [CB:0]   src_vrem [FB];
  logic [CB:0]   src_den  [FB];
  logic [FB-1:0] src_uq   [FB];
  logic [FB-1:0] src_vq   [FB];
  logic [CB+1:0] ustep    [FB];
  logic [CB+1:0] vstep    [FB];
  logic [FB-1:0] uq_nxt   [FB];
  logic [FB-1:0] vq_nxt   [FB];

  always_comb begin
    rdy[FB] = out_ready;
    for (int k = FB - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_comb begin
    for (int k = 0; k < FB; k++) begin
      if (k == 0) begin
        src_vld[k]  = in_valid;
        src_ctl[k]  = in_ctl;
        src_urem[k] = in_u_rem;
        src_vrem[k] = in_v_rem;
        src_den[k]  = in_den;
        src_uq[k]   = '0;
        src_vq[k]   = '0;
      end else begin
        src_vld[k]  = vld_r[k-1];
        src_ctl[k]  = ctl_r[k-1];
        src_urem[k] = urem_r[k-1];
        src_vrem[k] = vrem_r[k-1];
        src_den[k]  = den_r[k-1];
        src_uq[k]   = uq_r[k-1];
        src_vq[k]   = vq_r[k-1];
      end
      ustep[k]  = div_step(src_urem[k], src_den[k]);
      vstep[k]  = div_step(src_vrem[k], src_den[k]);
      uq_nxt[k] = {src_uq[k][FB-2:0], ustep[k][CB+1]};
      vq_nxt[k] = {src_vq[k][FB-2:0], vstep[k][CB+1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < FB; k++) begin
        if (rdy[k]) vld_r[k] <= src_vld[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < FB; k++) begin
      if (rdy[k] && src_vld[k]) begin
        ctl_r[k]  <= src_ctl[k];
        urem_r[k] <= ustep[k][CB:0];
        vrem_r[k] <= vstep[k][CB:0];
        den_r[k]  <= src_den[k];
        uq_r[k]   <= uq_nxt[k];
        vq_r[k]   <= vq_nxt[k];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[FB-1];
  assign out_ctl   = ctl_r[FB-1];
  assign out_u_quo = uq_r[FB-1];
  assign out_v_quo = vq_r[FB-1];

endmodule

// ----- rtl/cube_face_uv_mapper.sv -----
// ----------------------------------------------------------------------------
// cube_face_uv_mapper
// Picks the dominant cube face of a signed direction and maps the direction
// onto a requested or the dominant face, giving u and v in [0,1].
//
//   Channel   Direction  Ports
//   in_*      input      in_valid, in_stall, in_dir_x/y/z, in_face_select
//   out_*     output     out_valid, out_stall, out_dominant_face,
//                        out_used_face, out_u_coord, out_v_coord
//
// One transfer per cycle in and out at full rate while out_stall is low. The
// pipeline is three front stages, one divider stage per quotient bit and
// the output register.
// Every stage moves when it is empty or the stage after it moves, so a
// stall at the output fills bubbles before it reaches in_stall.
// Reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
module cube_face_uv_mapper
  import cfuv_pkg::*;
#(
  parameter int COMPONENT_BITS = CB_DEFAULT,
  parameter int FRACTION_BITS  = FB_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [COMPONENT_BITS-1:0] in_dir_x,
  input  logic signed [COMPONENT_BITS-1:0] in_dir_y,
  input  logic signed [COMPONENT_BITS-1:0] in_dir_z,
  input  logic [2:0]                       in_face_select,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [2:0]                       out_dominant_face,
  output logic [2:0]                       out_used_face,
  output logic [FRACTION_BITS:0]           out_u_coord,
  output logic [FRACTION_BITS:0]           out_v_coord
);

  localparam logic [FRACTION_BITS:0] UNIT = {1'b1, {FRACTION_BITS{1'b0}}};

  logic                       front_ready, front_valid;
  coord_ctl_t                 front_ctl;
  logic [COMPONENT_BITS:0]    front_u_rem, front_v_rem, front_den;

  logic                       div_valid, div_ready;
  coord_ctl_t                 div_ctl;
  logic [FRACTION_BITS-1:0]   div_u_quo, div_v_quo;

  logic                       out_valid_r;
  logic [2:0]                 out_dom_r, out_used_r;
  logic [FRACTION_BITS:0]     out_u_r, out_v_r;
  logic [FRACTION_BITS:0]     u_nxt, v_nxt;

  cfuv_front #(
    .COMPONENT_BITS(COMPONENT_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (front_ready),
    .dir_x      (in_dir_x),
    .dir_y      (in_dir_y),
    .dir_z      (in_dir_z),
    .face_select(in_face_select),
    .out_valid  (front_valid),
    .out_ready  (div_ready),
    .out_ctl    (front_ctl),
    .out_u_rem  (front_u_rem),
    .out_v_rem  (front_v_rem),
    .out_den    (front_den)
  );

  logic out_ready;

  cfuv_divider #(
    .COMPONENT_BITS(COMPONENT_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (front_valid),
    .in_ready (div_ready),
    .in_ctl   (front_ctl),
    .in_u_rem (front_u_rem),
    .in_v_rem (front_v_rem),
    .in_den   (front_den),
    .out_valid(div_valid),
    .out_ready(out_ready),
    .out_ctl  (div_ctl),
    .out_u_quo(div_u_quo),
    .out_v_quo(div_v_quo)
  );

  assign in_stall  = !front_ready;
  assign out_ready = !out_valid_r || !out_stall;

  // Edge coordinates are exactly 0.0 or 1.0; the rest come from the divider.
  always_comb begin
    if (div_ctl.u_edge) begin
      u_nxt = div_ctl.u_hi ? UNIT : '0;
    end else begin
      u_nxt = {1'b0, div_u_quo};
    end
    if (div_ctl.v_edge) begin
      v_nxt = div_ctl.v_hi ? UNIT : '0;
    end else begin
      v_nxt = {1'b0, div_v_quo};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && div_valid) begin
      out_dom_r  <= div_ctl.dominant_face;
      out_used_r <= div_ctl.used_face;
      out_u_r    <= u_nxt;
      out_v_r    <= v_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_dominant_face = out_dom_r;
  assign out_used_face     = out_used_r;
  assign out_u_coord       = out_u_r;
  assign out_v_coord       = out_v_r;

endmodule

// ----- rtl/cfuv_checker.sv -----
// ----------------------------------------------------------------------------
// cfuv_checker
// Port-level checks on the result channel of the face mapper.
// ----------------------------------------------------------------------------
module cfuv_checker
  import cfuv_pkg::*;
#(
  parameter int FRACTION_BITS = FB_DEFAULT
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [2:0]             out_dominant_face,
  input logic [2:0]             out_used_face,
  input logic [FRACTION_BITS:0] out_u_coord,
  input logic [FRACTION_BITS:0] out_v_coord
);

  localparam logic [FRACTION_BITS:0] UNIT = {1'b1, {FRACTION_BITS{1'b0}}};

  // A result held by a stall must stay put, values included.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_u_coord) &&
    $stable(out_v_coord) && $stable(out_used_face))
    else $error("stalled result changed");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_u_coord <= UNIT) && (out_v_coord <= UNIT))
    else $error("face coordinate above 1.0");

  a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_used_face <= FACE_NZ) && (out_dominant_face <= FACE_NZ))
    else $error("face code out of range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind cube_face_uv_mapper cfuv_checker #(
  .FRACTION_BITS(FRACTION_BITS)
) u_cfuv_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_dominant_face(out_dominant_face),
  .out_used_face    (out_used_face),
  .out_u_coord      (out_u_coord),
  .out_v_coord      (out_v_coord)
);

// ----- tb/sv/face_map_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// face_map_checker
// Watches both channels of the cube face mapper. Every input transfer is run
// through an independent model of face selection and u/v generation, and every
// result transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module face_map_checker
  import cfuv_pkg::*;
#(
  parameter int CB = CB_DEFAULT,
  parameter int FB = FB_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic signed [CB-1:0] in_dir_x,
  input  logic signed [CB-1:0] in_dir_y,
  input  logic signed [CB-1:0] in_dir_z,
  input  logic [2:0]           in_face_select,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [2:0]           out_dominant_face,
  input  logic [2:0]           out_used_face,
  input  logic [FB:0]          out_u_coord,
  input  logic [FB:0]          out_v_coord,
  output int                   mismatch_count,
  output int                   pending_count,
  output int                   checked_count
);

  typedef struct packed {
    logic [2:0] dominant;
    logic [2:0] face;
    logic [FB:0] u;
    logic [FB:0] v;
  } face_coords_t;

  face_coords_t coords_q[$];

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
    checked_count  = 0;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch on result %0d: %s", $realtime, checked_count, what);
  endtask

  function automatic longint magnitude(input longint a);
    return (a < 0) ? -a : a;
  endfunction

  // (d + n) / (2d) in unsigned fixed point, quotient truncated.
  function automatic logic [FB:0] unit_coord(input longint n, input longint d);
    longint q;
    q = ((d + n) << FB) / (2 * d);
    return q[FB:0];
  endfunction

  function automatic face_coords_t predict_face_coords(input longint x, input longint y,
                                                       input longint z, input logic [2:0] sel);
    longint comp[3];
    longint mags[3];
    logic [2:0] face;
    logic [1:0] ax, ui, vi;
    bit u_plus, v_plus, u_in, v_in, pos_face, opposite;
    longint d, nu, nv, eu, ev;
    face_coords_t r;
    comp[0] = x;
    comp[1] = y;
    comp[2] = z;
    for (int i = 0; i < 3; i++) mags[i] = magnitude(comp[i]);

    // Ties never go to x; y only wins when it strictly leads both others.
    if (mags[0] > mags[1] && mags[0] > mags[2]) begin
      r.dominant = (comp[0] > 0) ? FACE_PX : FACE_NX;
    end else if (mags[1] > mags[0] && mags[1] > mags[2]) begin
      r.dominant = (comp[1] > 0) ? FACE_PY : FACE_NY;
    end else begin
      r.dominant = (comp[2] > 0) ? FACE_PZ : FACE_NZ;
    end

    face = (sel > FACE_NZ) ? r.dominant : sel;
    case (face)
      FACE_PX: begin
        ax = AXIS_X; ui = AXIS_Z; u_plus = 1'b0; vi = AXIS_Y; v_plus = 1'b0;
      end
      FACE_NX: begin
        ax = AXIS_X; ui = AXIS_Z; u_plus = 1'b1; vi = AXIS_Y; v_plus = 1'b0;
      end
      FACE_PY: begin
        ax = AXIS_Y; ui = AXIS_X; u_plus = 1'b1; vi = AXIS_Z; v_plus = 1'b1;
      end
      FACE_NY: begin
        ax = AXIS_Y; ui = AXIS_X; u_plus = 1'b1; vi = AXIS_Z; v_plus = 1'b0;
      end
      FACE_PZ: begin
        ax = AXIS_Z; ui = AXIS_X; u_plus = 1'b1; vi = AXIS_Y; v_plus = 1'b0;
      end
      default: begin
        ax = AXIS_Z; ui = AXIS_X; u_plus = 1'b0; vi = AXIS_Y; v_plus = 1'b0;
      end
    endcase

    d  = mags[ax];
    nu = u_plus ? comp[ui] : -comp[ui];
    nv = v_plus ? comp[vi] : -comp[vi];
    // Edge value: the face sign when the component is positive, else its negation.
    eu = ((comp[ui] > 0) == u_plus) ? 1 : -1;
    ev = ((comp[vi] > 0) == v_plus) ? 1 : -1;
    u_in = d > mags[ui];
    v_in = d > mags[vi];

    if (u_in && v_in) begin
      pos_face = (face[0] == 1'b0);
      opposite = pos_face ? (comp[ax] < 0) : (comp[ax] > 0);
      if (opposite) begin
        if (magnitude(nu) > magnitude(nv)) nu = (nu > 0) ? d : -d;
        else nv = (nv > 0) ? d : -d;
      end
    end else if (u_in) begin
      nv = ev * d;
    end else if (v_in) begin
      nu = eu * d;
    end else begin
      // Both coordinates at an edge, including a zero face axis.
      nu = eu;
      nv = ev;
      d  = 1;
    end

    r.face = face;
    r.u = unit_coord(nu, d);
    r.v = unit_coord(nv, d);
    return r;
  endfunction

  always @(posedge clk) begin
    face_coords_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        checked_count++;
        if (coords_q.size() == 0) begin
          report_mismatch($sformatf(
              "result transfer with nothing expected (face %0d u %0d v %0d)",
              out_used_face, out_u_coord, out_v_coord));
        end else begin
          want = coords_q.pop_front();
          if (out_dominant_face !== want.dominant)
            report_mismatch($sformatf("dominant_face got %0d expected %0d",
                                      out_dominant_face, want.dominant));
          if (out_used_face !== want.face)
            report_mismatch($sformatf("used_face got %0d expected %0d",
                                      out_used_face, want.face));
          if (out_u_coord !== want.u)
            report_mismatch($sformatf("u_coord got %0d expected %0d", out_u_coord, want.u));
          if (out_v_coord !== want.v)
            report_mismatch($sformatf("v_coord got %0d expected %0d", out_v_coord, want.v));
        end
      end
      if (in_valid && !in_stall) begin
        coords_q.push_back(predict_face_coords(longint'(in_dir_x), longint'(in_dir_y),
                                               longint'(in_dir_z), in_face_select));
      end
      pending_count = coords_q.size();
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directions and face requests into the cube face mapper: a directed
// set of extremes, ties, opposite-face and edge cases, then a random mix.
// Input transfers come in bursts and the output stalls on shifting patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import cfuv_pkg::*;

  localparam int CB = CB_DEFAULT;
  localparam int FB = FB_DEFAULT;
  localparam int DIR_MAX = (1 << (CB - 1)) - 1;
  localparam int DIR_MIN = -(1 << (CB - 1));
  localparam int RANDOM_DIRECTIONS = 1900;
  localparam logic [2:0] FACE_SPARE = 3'd7;

  typedef enum {STALL_NONE, STALL_COIN, STALL_RUNS, STALL_PERIODIC} stall_style_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [CB-1:0] in_dir_x = '0;
  logic signed [CB-1:0] in_dir_y = '0;
  logic signed [CB-1:0] in_dir_z = '0;
  logic [2:0]           in_face_select = FACE_DOM;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [2:0]           out_dominant_face;
  logic [2:0]           out_used_face;
  logic [FB:0]          out_u_coord;
  logic [FB:0]          out_v_coord;

  int mismatch_count, pending_count, checked_count;
  int directions_sent = 0;
  int burst_left = 1;
  bit valid_high = 1'b0;

  stall_style_t stall_style = STALL_NONE;
  int style_left = 0;
  int run_left = 0;
  int stall_phase = 0;
  bit run_level = 1'b0;

  cube_face_uv_mapper #(
    .COMPONENT_BITS(CB),
    .FRACTION_BITS (FB)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_dir_x         (in_dir_x),
    .in_dir_y         (in_dir_y),
    .in_dir_z         (in_dir_z),
    .in_face_select   (in_face_select),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_dominant_face(out_dominant_face),
    .out_used_face    (out_used_face),
    .out_u_coord      (out_u_coord),
    .out_v_coord      (out_v_coord)
  );

  face_map_checker #(
    .CB(CB),
    .FB(FB)
  ) checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_dir_x         (in_dir_x),
    .in_dir_y         (in_dir_y),
    .in_dir_z         (in_dir_z),
    .in_face_select   (in_face_select),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_dominant_face(out_dominant_face),
    .out_used_face    (out_used_face),
    .out_u_coord      (out_u_coord),
    .out_v_coord      (out_v_coord),
    .mismatch_count   (mismatch_count),
    .pending_count    (pending_count),
    .checked_count    (checked_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The output side switches between stall styles at random.
  always @(posedge clk) begin
    if (style_left == 0) begin
      stall_style = stall_style_t'($urandom_range(0, 3));
      style_left = $urandom_range(20, 200);
    end else begin
      style_left--;
    end
    stall_phase++;
    case (stall_style)
      STALL_NONE: out_stall <= 1'b0;
      STALL_COIN: out_stall <= ($urandom_range(0, 99) < 40);
      STALL_RUNS: begin
        if (run_left == 0) begin
          run_level = !run_level;
          run_left = $urandom_range(1, 24);
        end else begin
          run_left--;
        end
        out_stall <= run_level;
      end
      default: out_stall <= (stall_phase % 3 != 0);
    endcase
  end

  // Holds one direction on the input until the transfer happens. At the end
  // of a burst the valid drops for a random gap; a zero gap keeps it high.
  task automatic send_direction(input logic signed [CB-1:0] x, input logic signed [CB-1:0] y,
                                input logic signed [CB-1:0] z, input logic [2:0] sel);
    int gap;
    in_valid <= 1'b1;
    in_dir_x <= x;
    in_dir_y <= y;
    in_dir_z <= z;
    in_face_select <= sel;
    valid_high = 1'b1;
    do @(posedge clk); while (in_stall);
    directions_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        valid_high = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic int random_sign(input int m);
    return ($urandom_range(0, 1) != 0) ? m : -m;
  endfunction

  initial begin
    int directed_count, pick, k;
    logic [1:0] ax;
    int m, lead;
    logic signed [CB-1:0] x, y, z;
    logic [2:0] sel;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Extremes on each axis, the zero vector, the spare select code and a corner onto NY.
    send_direction(CB'(DIR_MAX), 0, 0, FACE_DOM);
    send_direction(CB'(DIR_MIN), 0, 0, FACE_DOM);
    send_direction(0, CB'(DIR_MAX), 0, FACE_DOM);
    send_direction(0, CB'(DIR_MIN), 0, FACE_DOM);
    send_direction(0, 0, CB'(DIR_MAX), FACE_DOM);
    send_direction(0, 0, CB'(DIR_MIN), FACE_DOM);
    send_direction(0, 0, 0, FACE_DOM);
    send_direction(0, 0, 0, FACE_PX);
    send_direction(CB'(DIR_MIN), CB'(DIR_MIN), CB'(DIR_MIN), FACE_SPARE);
    send_direction(CB'(DIR_MAX), CB'(DIR_MIN), CB'(DIR_MAX), FACE_NY);
    // One x-led vector onto every face, the opposite face among them.
    for (int f = FACE_PX; f <= FACE_NZ; f++) send_direction(1000, -300, 200, 3'(f));
    // Ties fall to z unless y strictly leads.
    send_direction(500, 500, 500, FACE_DOM);
    send_direction(-500, 500, -100, FACE_DOM);
    send_direction(400, -900, 900, FACE_DOM);
    send_direction(400, -901, 900, FACE_DOM);
    // Opposite face with u leading, then with u and v equal.
    send_direction(1000, 100, 600, FACE_NX);
    send_direction(-1000, 300, -300, FACE_PX);
    // Face axis zero, and a component exactly as large as the face axis.
    send_direction(700, -200, 0, FACE_PZ);
    send_direction(800, 800, -5, FACE_PX);
    directed_count = directions_sent;

    for (int i = 0; i < RANDOM_DIRECTIONS; i++) begin
      pick = $urandom_range(0, 9);
      x = CB'($urandom);
      y = CB'($urandom);
      z = CB'($urandom);
      sel = 3'($urandom_range(0, 7));
      case (pick)
        4, 5: begin
          // Tiny components make ties and edge hits common.
          x = CB'($urandom_range(0, 6) - 3);
          y = CB'($urandom_range(0, 6) - 3);
          z = CB'($urandom_range(0, 6) - 3);
        end
        6: begin
          k = $urandom_range(0, 3);
          m = (k == 0) ? DIR_MAX : (k == 1) ? DIR_MIN : (k == 2) ? 0 : DIR_MIN + 1;
          ax = 2'($urandom_range(0, 2));
          if (ax == AXIS_X) x = CB'(m);
          else if (ax == AXIS_Y) y = CB'(m);
          else z = CB'(m);
        end
        7: begin
          m = $urandom_range(0, DIR_MAX);
          x = CB'(random_sign(m));
          y = CB'(random_sign(m));
          z = CB'(random_sign(m));
          k = $urandom_range(0, 3);
          if (k == 0) x = x >>> 1;
          else if (k == 1) y = y >>> 1;
          else if (k == 2) z = z >>> 1;
        end
        8: begin
          // Clear winner, mapped onto its own face or the opposite one.
          ax = 2'($urandom_range(0, 2));
          lead = $urandom_range(1, DIR_MAX);
          x = CB'(random_sign($urandom_range(0, lead - 1)));
          y = CB'(random_sign($urandom_range(0, lead - 1)));
          z = CB'(random_sign($urandom_range(0, lead - 1)));
          if (ax == AXIS_X) x = CB'(random_sign(lead));
          else if (ax == AXIS_Y) y = CB'(random_sign(lead));
          else z = CB'(random_sign(lead));
          sel = 3'(FACE_PX + 2 * ax + $urandom_range(0, 1));
        end
        9: begin
          sel = 3'($urandom_range(FACE_PX, FACE_NZ));
          if (sel < FACE_PY) x = 0;
          else if (sel < FACE_PZ) y = 0;
          else z = 0;
        end
        default: ;
      endcase
      send_direction(x, y, z, sel);
    end
    if (valid_high) in_valid <= 1'b0;

    do @(negedge clk); while (pending_count != 0);
    repeat (FB + 8) @(negedge clk);

    $display("Drove %0d directions (%0d directed, %0d random) in bursts",
             directions_sent, directed_count, directions_sent - directed_count);
    $display("against shifting output stalls; compared %0d results, %0d mismatches.",
             checked_count, mismatch_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Run timed out with %0d results outstanding.", pending_count);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
